@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the tokenizer RTL, used by cst_queue. Every macro samples on the
// rising edge of clock and is disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge
`define CST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cst_pkg.sv @@
// ---------------------------------------------------------------------------
// cst_pkg
// Shared types and defaults for the character stream tokenizer.
// ---------------------------------------------------------------------------
package cst_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int TOKEN_POS_BITS      = 16;

   typedef enum logic [3:0] {
      KIND_EOF    = 4'd0,
      KIND_ERROR  = 4'd1,
      KIND_IDENT  = 4'd2,
      KIND_KWVAR  = 4'd3,
      KIND_NUMBER = 4'd4,
      KIND_POPEN  = 4'd5,
      KIND_PCLOSE = 4'd6,
      KIND_SEMI   = 4'd7,
      KIND_PLUS   = 4'd8,
      KIND_MINUS  = 4'd9,
      KIND_STAR   = 4'd10,
      KIND_SLASH  = 4'd11,
      KIND_EQ     = 4'd12
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [TOKEN_POS_BITS-1:0] start;
      logic [TOKEN_POS_BITS-1:0] length;
   } token_type;

   // All tokens caused by one byte: a flushed token and/or the byte's own one
   typedef struct packed {
      token_type first;
      token_type second;
      logic      two;
   } record_type;

endpackage

@@ rtl/cst_front.sv @@
// ---------------------------------------------------------------------------
// cst_front
// Byte classifier and scan state. Takes one byte per cycle while accept is high, tracks the
// pending token and builds the record of tokens that the byte releases.
// ---------------------------------------------------------------------------
module cst_front #(
   parameter int OFFSET_BITS = cst_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_code,
   input  logic                end_of_text,
   output logic                push,
   output cst_pkg::record_type record
);
   import cst_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_BAD
   } mode_type;

   typedef enum logic [2:0] {
      KW_EMPTY,
      KW_V,
      KW_VA,
      KW_VAR,
      KW_FAIL
   } kw_type;

   localparam logic [7:0] CHAR_POPEN  = 8'h28;
   localparam logic [7:0] CHAR_PCLOSE = 8'h29;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_EQ     = 8'h3D;
   localparam logic [7:0] CHAR_UNDER  = 8'h5F;
   localparam logic [7:0] CHAR_V      = 8'h76;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_R      = 8'h72;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   mode_type               mode_ff, mode_in;
   kw_type                 kw_ff, kw_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] cur_ff, cur_in;

   logic                   blank_byte, digit_byte, is_word, is_sep;
   kind_type               sep_kind;
   logic [OFFSET_BITS-1:0] cur_adv;
   logic                   pend_valid;
   token_type              pend_tok, tail_tok;
   logic                   emit;

   // Classify the byte
   always_comb begin
      blank_byte = (char_code == 8'h20) || (char_code == 8'h0A) || (char_code == 8'h09) ||
                   (char_code == 8'h0C) || (char_code == 8'h0B) || (char_code == 8'h0D);
      digit_byte = (char_code >= 8'h30) && (char_code <= 8'h39);
      is_word  = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                 ((char_code >= 8'h41) && (char_code <= 8'h5A)) || (char_code == CHAR_UNDER);
      case (char_code)
         CHAR_POPEN:  sep_kind = KIND_POPEN;
         CHAR_PCLOSE: sep_kind = KIND_PCLOSE;
         CHAR_SEMI:   sep_kind = KIND_SEMI;
         CHAR_PLUS:   sep_kind = KIND_PLUS;
         CHAR_MINUS:  sep_kind = KIND_MINUS;
         CHAR_STAR:   sep_kind = KIND_STAR;
         CHAR_SLASH:  sep_kind = KIND_SLASH;
         CHAR_EQ:     sep_kind = KIND_EQ;
         default:     sep_kind = KIND_EOF;
      endcase
      is_sep = (sep_kind != KIND_EOF);
   end

   // Saturating advance of the byte offset
   assign cur_adv = (cur_ff == OFFSET_MAX) ? cur_ff : cur_ff + 1'b1;

   // Build the pending token, the byte's own token and the record to push
   always_comb begin
      pend_valid      = (mode_ff != MODE_IDLE);
      pend_tok.start  = TOKEN_POS_BITS'(start_ff);
      pend_tok.length = TOKEN_POS_BITS'(cur_ff - start_ff);
      case (mode_ff)
         MODE_IDENT:  pend_tok.kind = (kw_ff == KW_VAR) ? KIND_KWVAR : KIND_IDENT;
         MODE_NUMBER: pend_tok.kind = KIND_NUMBER;
         MODE_BAD: begin
            pend_tok.kind   = KIND_ERROR;
            pend_tok.start  = TOKEN_POS_BITS'(cur_ff);
            pend_tok.length = '0;
         end
         default:     pend_tok.kind = KIND_EOF;
      endcase

      tail_tok.kind   = end_of_text ? KIND_EOF : sep_kind;
      tail_tok.start  = TOKEN_POS_BITS'(cur_ff);
      tail_tok.length = end_of_text ? TOKEN_POS_BITS'(0) : TOKEN_POS_BITS'(1);

      record.first  = pend_valid ? pend_tok : tail_tok;
      record.second = tail_tok;
      record.two    = pend_valid && (end_of_text || is_sep);

      emit = end_of_text || is_sep || (blank_byte && pend_valid);
      push = accept && emit;
   end

   // Next scan state
   always_comb begin
      mode_in  = mode_ff;
      kw_in    = kw_ff;
      start_in = start_ff;
      cur_in   = cur_ff;
      if (end_of_text) begin
         mode_in  = MODE_IDLE;
         kw_in    = KW_EMPTY;
         start_in = '0;
         cur_in   = '0;
      end else if (blank_byte || is_sep) begin
         mode_in = MODE_IDLE;
         kw_in   = KW_EMPTY;
         cur_in  = cur_adv;
      end else begin
         cur_in = cur_adv;
         case (mode_ff)
            MODE_IDLE: begin
               start_in = cur_ff;
               if (is_word) begin
                  mode_in = MODE_IDENT;
                  kw_in   = (char_code == CHAR_V) ? KW_V : KW_FAIL;
               end else if (digit_byte) begin
                  mode_in = MODE_NUMBER;
               end else begin
                  mode_in = MODE_BAD;
               end
            end
            MODE_IDENT: begin
               if (is_word || digit_byte) begin
                  if (kw_ff == KW_V && char_code == CHAR_A) begin
                     kw_in = KW_VA;
                  end else if (kw_ff == KW_VA && char_code == CHAR_R) begin
                     kw_in = KW_VAR;
                  end else begin
                     kw_in = KW_FAIL;
                  end
               end else begin
                  mode_in = MODE_BAD;
               end
            end
            MODE_NUMBER: begin
               if (!digit_byte) begin
                  mode_in = MODE_BAD;
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   // Hold or update the scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         kw_ff    <= KW_EMPTY;
         start_ff <= '0;
         cur_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         kw_ff    <= kw_in;
         start_ff <= start_in;
         cur_ff   <= cur_in;
      end
   end

endmodule

@@ rtl/cst_queue.sv @@
// ---------------------------------------------------------------------------
// cst_queue
// Back end: a short queue of token records and the sequencer that hands out
// one token per pop, marking the last token of each record.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cst_queue #(
   parameter int DEPTH = cst_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cst_pkg::record_type record,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output cst_pkg::token_type  token,
   output logic                last
);
   import cst_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   record_type            mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  sel_ff, sel_in;
   record_type            head;
   logic                  take, deq;

   // Present the head record's current token
   always_comb begin
      head  = mem_ff[rd_ptr_ff];
      empty = (count_ff == '0);
      full  = (count_ff == CNT_FULL);
      token = sel_ff ? head.second : head.first;
      last  = sel_ff || !head.two;
   end

   // Advance slot select and pointers
   always_comb begin
      take      = pop && !empty;
      deq       = take && last;
      sel_in    = sel_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (take) begin
         sel_in = !last;
      end
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Store pushed records
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= record;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sel_ff    <= sel_in;
      end
   end

   `CST_ASSERT(a_no_overflow, count_ff <= CNT_FULL, "record queue count beyond depth")
   `CST_ASSERT(a_no_push_full, push |-> !full, "record pushed into full queue")
   `CST_ASSERT(a_sel_two, sel_ff |-> (!empty && head.two), "second slot shown without record")
   `CST_ASSERT_NEXT(a_sel_step, take && !last, sel_ff, "second token not shown after first")

endmodule

@@ rtl/char_stream_tokenizer.sv @@
// ---------------------------------------------------------------------------
// char_stream_tokenizer
// Streaming lexer: one text byte or end marker in, tokens out as kind,
// start offset and length, with the last token of each byte flagged.
// ---------------------------------------------------------------------------
// A pushed byte's record is registered in the queue and shows on the rsp_ ports
// once older records are popped. Takes one byte per cycle while req_full is low.
// A byte that releases two tokens takes two pops; the record queue
// (QUEUE_DEPTH entries) absorbs that so pushes continue while results wait.
// Reset: synchronous; clears the scan state to idle at offset zero and
// empties the queue. No clearing pass is needed.
module char_stream_tokenizer #(
   parameter int OFFSET_BITS = cst_pkg::OFFSET_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import cst_pkg::*;

   logic       accept;
   logic       push;
   record_type record;
   token_type  token;

   assign accept = req_push && !req_full;

   cst_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_char_code),
      .end_of_text (req_end_of_text),
      .push        (push),
      .record      (record)
   );

   cst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .record (record),
      .full   (req_full),
      .pop    (rsp_pop),
      .empty  (rsp_empty),
      .token  (token),
      .last   (rsp_last_of_run)
   );

   // Drive the result ports
   assign rsp_token_kind   = token.kind;
   assign rsp_token_start  = token.start;
   assign rsp_token_length = token.length;

endmodule
